FILE: rtl/core/slp_pkg.sv
// Shared types and constants of the sync-length-sum frame parser.
package slp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;

  localparam logic [15:0] MAX_LEN_RESET = 16'd248;
  localparam logic [3:0]  TRL_CNT_RESET = 4'd2;

  localparam logic [1:0] CFG_MAX_LEN = 2'd0;
  localparam logic [1:0] CFG_TRL_CNT = 2'd1;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_OK      = 2'd1;
  localparam logic [1:0] KIND_SUM_ERR = 2'd2;
  localparam logic [1:0] KIND_LEN_ERR = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  command;
    logic [7:0]  sequence_res;
    logic [15:0] frame_length;
  } res_t;

  typedef struct packed {
    logic [15:0] max_len;
    logic [3:0]  trl_cnt;
  } cfg_t;

endpackage

FILE: rtl/core/sync_length_sum_frame_parser_top.sv
// Top level of the sync-length-sum frame parser: config registers and datapath.
// Each result is registered in the result buffer and is shown at the output from there.
// Throughput: one byte per cycle; the two-entry result buffer absorbs output stalls.
// The input stalls only while both result entries wait to be taken.
// Reset (async, active low) returns to sync hunting, empties the buffer and loads
// max_length with 248 and trailer_count with 2.
module sync_length_sum_frame_parser_top import slp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  command_o,
  output logic [7:0]  sequence_res_o,
  output logic [15:0] frame_length_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t cfg_q;
  logic space;
  logic push;
  res_t res_new;
  res_t res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_len <= MAX_LEN_RESET;
      cfg_q.trl_cnt <= TRL_CNT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MAX_LEN) begin
        cfg_q.max_len <= cfg_data_i;
      end else if (cfg_idx_i == CFG_TRL_CNT) begin
        cfg_q.trl_cnt <= cfg_data_i[3:0];
      end
    end
  end

  slp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .space_i    (space),
    .cfg_i      (cfg_q),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .res_o      (res_new)
  );

  slp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res_new),
    .out_stall_i (out_stall_i),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign kind_o         = res_out.kind;
  assign payload_byte_o = res_out.payload_byte;
  assign command_o      = res_out.command;
  assign sequence_res_o = res_out.sequence_res;
  assign frame_length_o = res_out.frame_length;

endmodule

FILE: rtl/core/slp_parser.sv
// Per-byte deframing state machine with checksum and length checks.
module slp_parser import slp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] rx_byte_i,
  input  logic       space_i,
  input  cfg_t       cfg_i,
  output logic       in_stall_o,
  output logic       push_o,
  output res_t       res_o
);

  localparam logic [3:0] PH_HUNT   = 4'd0;
  localparam logic [3:0] PH_SYNC2  = 4'd1;
  localparam logic [3:0] PH_LEN_LO = 4'd2;
  localparam logic [3:0] PH_LEN_HI = 4'd3;
  localparam logic [3:0] PH_SEQ    = 4'd4;
  localparam logic [3:0] PH_CMD    = 4'd5;
  localparam logic [3:0] PH_DATA   = 4'd6;
  localparam logic [3:0] PH_CHK    = 4'd7;
  localparam logic [3:0] PH_TRAIL  = 4'd8;

  logic [3:0]  phase_q, phase_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  cmd_q, cmd_d;

  logic        accept;
  logic        emit;
  logic [15:0] new_len;
  logic [15:0] cnt_dec;
  logic [15:0] cnt_inc;
  logic [15:0] need;
  logic [7:0]  sum_add;

  assign in_stall_o = !space_i;
  assign accept     = in_valid_i && space_i;
  assign push_o     = accept && emit;

  assign new_len = {rx_byte_i, len_lo_q};
  assign cnt_dec = cnt_q - 16'd1;
  assign cnt_inc = cnt_q + 16'd1;
  assign sum_add = sum_q + rx_byte_i;
  // A trailer count of zero still waits for one trailer byte.
  assign need    = (cfg_i.trl_cnt == 4'd0) ? 16'd1 : {12'd0, cfg_i.trl_cnt};

  always_comb begin
    phase_d  = phase_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    len_lo_d = len_lo_q;
    len_d    = len_q;
    seq_d    = seq_q;
    cmd_d    = cmd_q;
    emit     = 1'b0;
    res_o    = '{kind: KIND_PAYLOAD, payload_byte: 8'd0, command: cmd_q,
                 sequence_res: seq_q, frame_length: len_q};
    case (phase_q)
      PH_HUNT: begin
        if (rx_byte_i == SYNC_FIRST) begin
          sum_d   = rx_byte_i;
          phase_d = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (rx_byte_i == SYNC_SECOND) begin
          sum_d   = sum_add;
          phase_d = PH_LEN_LO;
        end else if (rx_byte_i == SYNC_FIRST) begin
          sum_d = rx_byte_i;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_LEN_LO: begin
        len_lo_d = rx_byte_i;
        sum_d    = sum_add;
        phase_d  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        sum_d = sum_add;
        len_d = new_len;
        if (new_len > cfg_i.max_len) begin
          phase_d = PH_HUNT;
          emit    = 1'b1;
          res_o   = '{kind: KIND_LEN_ERR, payload_byte: 8'd0, command: 8'd0,
                      sequence_res: 8'd0, frame_length: new_len};
        end else begin
          phase_d = PH_SEQ;
        end
      end
      PH_SEQ: begin
        seq_d   = rx_byte_i;
        sum_d   = sum_add;
        phase_d = PH_CMD;
      end
      PH_CMD: begin
        cmd_d   = rx_byte_i;
        sum_d   = sum_add;
        cnt_d   = len_q;
        phase_d = (len_q == 16'd0) ? PH_CHK : PH_DATA;
      end
      PH_DATA: begin
        sum_d = sum_add;
        cnt_d = cnt_dec;
        if (cnt_dec == 16'd0) begin
          phase_d = PH_CHK;
        end
        emit               = 1'b1;
        res_o.kind         = KIND_PAYLOAD;
        res_o.payload_byte = rx_byte_i;
      end
      PH_CHK: begin
        if (rx_byte_i == sum_q) begin
          cnt_d   = 16'd0;
          phase_d = PH_TRAIL;
        end else begin
          phase_d    = PH_HUNT;
          emit       = 1'b1;
          res_o.kind = KIND_SUM_ERR;
        end
      end
      PH_TRAIL: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= need) begin
          cnt_d      = 16'd0;
          phase_d    = PH_HUNT;
          emit       = 1'b1;
          res_o.kind = KIND_OK;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      sum_q    <= 8'd0;
      cnt_q    <= 16'd0;
      len_lo_q <= 8'd0;
      len_q    <= 16'd0;
      seq_q    <= 8'd0;
      cmd_q    <= 8'd0;
    end else if (accept) begin
      phase_q  <= phase_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      len_lo_q <= len_lo_d;
      len_q    <= len_d;
      seq_q    <= seq_d;
      cmd_q    <= cmd_d;
    end
  end

`ifndef SYNTHESIS
  a_payload_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && res_o.kind == KIND_PAYLOAD) |-> phase_q == PH_DATA)
    else $error("payload item emitted outside the data phase");

  a_result_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && res_o.kind != KIND_PAYLOAD) |=> phase_q == PH_HUNT)
    else $error("frame result did not return to sync hunting");

  a_data_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> cnt_q != 16'd0)
    else $error("data phase entered with zero bytes left");
`endif

endmodule

FILE: rtl/core/slp_out_buf.sv
// Two-entry result buffer that decouples the parser from output stalls.
module slp_out_buf import slp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  input  logic out_stall_i,
  output logic space_o,
  output logic out_valid_o,
  output res_t res_o
);

  logic [1:0] cnt_q, cnt_d;
  res_t       head_q, head_d;
  res_t       skid_q, skid_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign space_o     = (cnt_q != 2'd2);
  assign res_o       = head_q;
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    skid_d = skid_q;
    case (cnt_q)
      2'd0: begin
        if (push_i) begin
          head_d = res_i;
          cnt_d  = 2'd1;
        end
      end
      2'd1: begin
        if (pop && push_i) begin
          head_d = res_i;
        end else if (pop) begin
          cnt_d = 2'd0;
        end else if (push_i) begin
          skid_d = res_i;
          cnt_d  = 2'd2;
        end
      end
      2'd2: begin
        // No push is possible while full.
        if (pop) begin
          head_d = skid_q;
          cnt_d  = 2'd1;
        end
      end
      default: begin
        cnt_d = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != 2'd2)
    else $error("result pushed into a full buffer");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("buffer count out of range");

  a_skid_moves_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && pop) |=> res_o == $past(skid_q))
    else $error("waiting item lost when head was taken");
`endif

endmodule
